>>> hw/rtl/pdmdec_pkg.sv
// pdmdec_pkg: shared types and constants of the pdm to pcm decimator
// command and status structs between controller and datapath, controller state enum
// no dependencies
`timescale 1ns / 1ps

package pdmdec_pkg;

	localparam int unsigned MAX_DECIMATION_DEF = 255;
	localparam logic [7:0]  CFG_RESET          = 8'd64;
	localparam int unsigned DIV_STEPS          = 23;
	localparam int unsigned SHIFT_LP           = 2;
	localparam int unsigned SHIFT_DC           = 6;
	localparam int unsigned SHIFT_OUT          = 8;
	localparam int          PCM_MAX            = 32767;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIT,
		ST_DIV,
		ST_LP1,
		ST_LP2,
		ST_DC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_byte;
		logic do_bit;
		logic do_div;
		logic do_lp1;
		logic do_lp2;
		logic do_dc;
		logic do_emit;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic bit_last;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> hw/rtl/pdmdec_ctrl.sv
// pdmdec_ctrl: sequencer of the decimator, walks bits, divide, filters and output
// depends on pdmdec_pkg
`timescale 1ns / 1ps

module pdmdec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pdmdec_pkg::status_t status,
	output logic                in_ready,
	output pdmdec_pkg::cmd_t    cmd
);

	pdmdec_pkg::state_t state_q;
	pdmdec_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdmdec_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pdmdec_pkg::ST_IDLE: begin
				if (in_valid) state_nx = pdmdec_pkg::ST_BIT;
			end
			pdmdec_pkg::ST_BIT: begin
				if (status.frame_end) state_nx = pdmdec_pkg::ST_DIV;
				else if (status.bit_last) state_nx = pdmdec_pkg::ST_IDLE;
			end
			pdmdec_pkg::ST_DIV: begin
				if (status.div_done) state_nx = pdmdec_pkg::ST_LP1;
			end
			pdmdec_pkg::ST_LP1: state_nx = pdmdec_pkg::ST_LP2;
			pdmdec_pkg::ST_LP2: state_nx = pdmdec_pkg::ST_DC;
			pdmdec_pkg::ST_DC:  state_nx = pdmdec_pkg::ST_EMIT;
			pdmdec_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_nx = status.bit_last ? pdmdec_pkg::ST_IDLE : pdmdec_pkg::ST_BIT;
				end
			end
			default: state_nx = pdmdec_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pdmdec_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_byte = in_valid;
			end
			pdmdec_pkg::ST_BIT:  cmd.do_bit  = 1'b1;
			pdmdec_pkg::ST_DIV:  cmd.do_div  = 1'b1;
			pdmdec_pkg::ST_LP1:  cmd.do_lp1  = 1'b1;
			pdmdec_pkg::ST_LP2:  cmd.do_lp2  = 1'b1;
			pdmdec_pkg::ST_DC:   cmd.do_dc   = 1'b1;
			pdmdec_pkg::ST_EMIT: cmd.do_emit = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

>>> hw/rtl/pdmdec_datapath.sv
// pdmdec_datapath: frame counters, restoring divider, filters and output register
// depends on pdmdec_pkg, driven by pdmdec_ctrl
`timescale 1ns / 1ps

module pdmdec_datapath #(
	parameter int unsigned MaxDecimation = pdmdec_pkg::MAX_DECIMATION_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdmdec_pkg::cmd_t    cmd,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  logic [7:0]          in_byte,
	input  logic                out_ready,
	output pdmdec_pkg::status_t status,
	output logic                out_valid,
	output logic [15:0]         out_pcm,
	output logic                out_last
);

	logic [7:0] cfg_q;
	logic [7:0] byte_q;
	logic [2:0] idx_q;
	logic [7:0] ones_q;
	logic [7:0] bits_q;

	logic [7:0]  rem_q;
	logic [23:0] quo_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        last_q;

	logic signed [24:0] lp1_q;
	logic signed [24:0] lp2_q;
	logic signed [24:0] dc_q;

	logic        valid_q;
	logic [15:0] pcm_q;
	logic        tlast_q;

	logic [7:0]        d_eff;
	logic [7:0]        ones_nx;
	logic [7:0]        bits_nx;
	logic              frame_end;
	logic              bit_last;
	logic              out_free;
	logic signed [9:0] centered;
	logic [9:0]        cen_abs;
	logic [7:0]        mag;
	logic              q0;
	logic [8:0]        r2;
	logic              ge;
	logic [7:0]        rem_nx;
	logic signed [24:0] sample;
	logic signed [25:0] d1, s1, d2, s2, d3, s3, pd;
	logic signed [17:0] ps;
	logic [15:0]        pcm_sat;

	// clamp of the factor into 1..MaxDecimation
	always_comb begin
		if (cfg_q == 8'd0) d_eff = 8'd1;
		else if (cfg_q > 8'(MaxDecimation)) d_eff = 8'(MaxDecimation);
		else d_eff = cfg_q;
	end

	assign ones_nx   = ones_q + {7'd0, byte_q[idx_q]};
	assign bits_nx   = bits_q + 8'd1;
	assign frame_end = bits_nx >= d_eff;
	assign bit_last  = idx_q == 3'd7;
	assign out_free  = !valid_q || out_ready;

	// centred count, magnitude limited to the factor
	assign centered = $signed({1'b0, ones_nx, 1'b0}) - $signed({2'd0, d_eff});
	assign cen_abs  = centered[9] ? 10'(-centered) : centered;
	assign mag      = (cen_abs > {2'd0, d_eff}) ? d_eff : cen_abs[7:0];
	assign q0       = mag >= d_eff;

	// one restoring step
	assign r2     = {rem_q, 1'b0};
	assign ge     = r2 >= {1'b0, d_eff};
	assign rem_nx = ge ? 8'(r2 - {1'b0, d_eff}) : r2[7:0];

	assign sample = neg_q ? 25'(-$signed({1'b0, quo_q})) : $signed({1'b0, quo_q});

	assign d1 = $signed({sample[24], sample}) - $signed({lp1_q[24], lp1_q});
	assign s1 = $signed({lp1_q[24], lp1_q}) + (d1 >>> pdmdec_pkg::SHIFT_LP);
	assign d2 = $signed({lp1_q[24], lp1_q}) - $signed({lp2_q[24], lp2_q});
	assign s2 = $signed({lp2_q[24], lp2_q}) + (d2 >>> pdmdec_pkg::SHIFT_LP);
	assign d3 = $signed({lp2_q[24], lp2_q}) - $signed({dc_q[24], dc_q});
	assign s3 = $signed({dc_q[24], dc_q}) + (d3 >>> pdmdec_pkg::SHIFT_DC);
	assign pd = d3;
	assign ps = $signed(pd[25:pdmdec_pkg::SHIFT_OUT]);

	always_comb begin
		if (ps > 18'sd32767) pcm_sat = 16'(pdmdec_pkg::PCM_MAX);
		else if (ps < -18'sd32767) pcm_sat = 16'(-pdmdec_pkg::PCM_MAX);
		else pcm_sat = ps[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= pdmdec_pkg::CFG_RESET;
			idx_q   <= 3'd0;
			ones_q  <= 8'd0;
			bits_q  <= 8'd0;
			cnt_q   <= 5'd0;
			lp1_q   <= '0;
			lp2_q   <= '0;
			dc_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) cfg_q <= cfg_wr_data;
			if (cmd.load_byte) idx_q <= 3'd0;
			if (cmd.do_bit) begin
				if (frame_end) begin
					ones_q <= 8'd0;
					bits_q <= 8'd0;
					cnt_q  <= 5'd0;
				end else begin
					ones_q <= ones_nx;
					bits_q <= bits_nx;
					if (!bit_last) idx_q <= idx_q + 3'd1;
				end
			end
			if (cmd.do_div) cnt_q <= cnt_q + 5'd1;
			if (cmd.do_lp1) lp1_q <= s1[24:0];
			if (cmd.do_lp2) lp2_q <= s2[24:0];
			if (cmd.do_dc) dc_q <= s3[24:0];
			if (cmd.do_emit && out_free) begin
				valid_q <= 1'b1;
				if (!bit_last) idx_q <= idx_q + 3'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) byte_q <= in_byte;
		if (cmd.do_bit && frame_end) begin
			neg_q  <= centered[9];
			quo_q  <= {23'd0, q0};
			rem_q  <= q0 ? 8'd0 : mag;
			last_q <= {5'd0, 3'd7 - idx_q} < d_eff;
		end
		if (cmd.do_div) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[22:0], ge};
		end
		if (cmd.do_emit && out_free) begin
			pcm_q   <= pcm_sat;
			tlast_q <= last_q;
		end
	end

	assign status.frame_end = frame_end;
	assign status.bit_last  = bit_last;
	assign status.div_done  = cnt_q == 5'(pdmdec_pkg::DIV_STEPS - 1);
	assign status.out_free  = out_free;

	assign out_valid = valid_q;
	assign out_pcm   = pcm_q;
	assign out_last  = tlast_q;

endmodule

>>> hw/rtl/pdm_to_pcm_decimator_unit.sv
// pdm to pcm decimator: one pdm byte in, lsb first, zero to eight pcm samples out
// after its last bit is counted, a sample goes through the divide, two low-pass steps and the dc step
// into the output register; emit waits while the output is stalled, and a new byte is taken only when idle
// the sample scaling is done by a 23-step restoring divider
// reset: asynchronous active-low arst_n clears counters, filters, output valid, factor to 64
`timescale 1ns / 1ps

module pdm_to_pcm_decimator_unit #(
	parameter int unsigned MaxDecimation = pdmdec_pkg::MAX_DECIMATION_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: pdm bits per pcm sample
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pdm_byte
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pcm_sample
	output logic        m_tlast    // last_of_byte
);

	// command and status between sequencer and datapath
	pdmdec_pkg::cmd_t    cmd;
	pdmdec_pkg::status_t status;

	// sequencer: idle, one bit per cycle until a frame ends, divide, three filter steps, emit
	pdmdec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.status   (status),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	// datapath: frame counters, divider, low-pass and dc tracker, output register
	// the output register lets the next byte in while a sample still waits
	pdmdec_datapath #(
		.MaxDecimation (MaxDecimation)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_byte     (s_tdata),
		.out_ready   (m_tready),
		.status      (status),
		.out_valid   (m_tvalid),
		.out_pcm     (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

>>> hw/rtl/pdmdec_checker.sv
// pdmdec_checker: port-level assertions of the decimator, bound to the top level
// depends on pdm_to_pcm_decimator_unit ports only
`timescale 1ns / 1ps

module pdmdec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// a stalled output request stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output request dropped under stall");

	// a stalled output request keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output payload changed under stall");

	// saturation never yields the most negative code
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("sample outside symmetric range");

	// a taken byte closes the input right after it was taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input open right after a byte was taken");

endmodule

bind pdm_to_pcm_decimator_unit pdmdec_checker u_pdmdec_checker (.*);
